// ----- sv/scba_pkg.sv -----
// Shared types and constants of the size class bitmap slot allocator.
package scba_pkg;

  localparam int SIZE_W    = 16;
  localparam int ADDR_W    = 12;
  localparam int STATUS_W  = 3;
  localparam int MIN_W     = 13;
  localparam int STEP_W    = 9;
  localparam int DVD_W     = 14;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LARGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_SIZE_MIN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_MAX  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_STEP = 2'd2;

  localparam logic [MIN_W-1:0]  SIZE_MIN_RST  = 13'd8;
  localparam logic [MIN_W-1:0]  SIZE_MAX_RST  = 13'd128;
  localparam logic [STEP_W-1:0] SIZE_STEP_RST = 9'd8;
  localparam logic [STEP_W-1:0] STEP_FLOOR    = 9'd4;

  typedef struct packed {
    logic [MIN_W-1:0]  size_min;
    logic [MIN_W-1:0]  size_max;
    logic [STEP_W-1:0] size_step;
  } cfg_t;

endpackage

// ----- sv/scba_if.sv -----
// Request and response channel interfaces of the slot allocator.
interface scba_req_if;
  import scba_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;
  modport source (output valid, command, size, address, input ready);
  modport sink (input valid, command, size, address, output ready);
endinterface

interface scba_rsp_if;
  import scba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address_res;
  modport source (output valid, status, address_res, input ready);
  modport sink (input valid, status, address_res, output ready);
endinterface

// ----- sv/scba_ram.sv -----
// Generic simple dual-port RAM with registered read.
module scba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/scba_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module scba_div #(
  parameter int DVD_W = 14,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] acc;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] qr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial     = {acc, qr[DVD_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign quotient  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      qr  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      acc <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      qr  <= {qr[DVD_W-2:0], fits};
    end
  end

endmodule

// ----- sv/scba_cfg.sv -----
// APB configuration registers of the slot allocator.
module scba_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scba_pkg::APB_AW-1:0]  paddr,
  input  logic [scba_pkg::APB_DW-1:0]  pwdata,
  output logic [scba_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output scba_pkg::cfg_t               cfg
);
  import scba_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_min  <= SIZE_MIN_RST;
      cfg.size_max  <= SIZE_MAX_RST;
      cfg.size_step <= SIZE_STEP_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SIZE_MIN:  cfg.size_min  <= pwdata[MIN_W-1:0];
        REG_SIZE_MAX:  cfg.size_max  <= pwdata[MIN_W-1:0];
        REG_SIZE_STEP: cfg.size_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIZE_MIN:  prdata = APB_DW'(cfg.size_min);
      REG_SIZE_MAX:  prdata = APB_DW'(cfg.size_max);
      REG_SIZE_STEP: prdata = APB_DW'(cfg.size_step);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- sv/size_class_bitmap_slot_allocator.sv -----
// Size class bitmap slot allocator: top level with control sequencer and state memories.
// One transaction is handled at a time. An allocate runs two passes of a bit-serial
// divider by the class step (14 quotient bits, one per cycle); a free splits its address
// into class, word and bit fields directly. An allocate then reads the class count and
// checks the bitmap words of its class one after another until a free one is found; a
// class out of range or a full class ends it early. A free reads its word and count
// once; a zero or too large size needs no divider. The free bitmap (one word per row,
// classes laid out row after row) and the per-class free counts live in RAMs read and
// written back by the sequencer; per-row valid bits make reset take effect at once, with
// no clearing pass. A finished result waits in an output register, so the next request
// is taken meanwhile.
module size_class_bitmap_slot_allocator #(
  parameter int NUM_CLASSES = 16,
  parameter int SLOTS       = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scba_pkg::APB_AW-1:0]  paddr,
  input  logic [scba_pkg::APB_DW-1:0]  pwdata,
  output logic [scba_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  scba_req_if.sink                     req,
  scba_rsp_if.source                   rsp
);
  import scba_pkg::*;

  localparam int WPC      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int BM_DEPTH = NUM_CLASSES * WPC;
  localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int WI_W     = (WPC > 1) ? $clog2(WPC) : 1;
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int DVS_W    = STEP_W;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b0_0000_0001,
    S_DIV_Q      = 9'b0_0000_0010,
    S_DIV_R      = 9'b0_0000_0100,
    S_CLASS      = 9'b0_0000_1000,
    S_CNT        = 9'b0_0001_0000,
    S_SCAN_RD    = 9'b0_0010_0000,
    S_SCAN_CHK   = 9'b0_0100_0000,
    S_FREE_CHK   = 9'b0_1000_0000,
    S_OUT        = 9'b1_0000_0000
  } state_t;

  function automatic logic [WORD_BITS-1:0] word_init(input logic [WI_W-1:0] w);
    int left;
    logic [WORD_BITS-1:0] v;
    left = SLOTS - int'(w) * WORD_BITS;
    if (left > WORD_BITS) begin
      left = WORD_BITS;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      v[i] = (i < left);
    end
    return v;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] wd);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (wd[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  cfg_t cfg;

  state_t state, state_next;

  logic                 div_start;
  logic                 div_done;
  logic [DVD_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic [DVD_W-1:0]     div_quotient;

  logic [STEP_W-1:0]    step_eff;
  logic [DVD_W-1:0]     quo;
  logic [DVD_W-1:0]     rq;
  logic [DVD_W-1:0]     cls_wide;
  logic [CLS_W-1:0]     cls;
  logic [WI_W-1:0]      word_idx;
  logic [BIT_W-1:0]     bit_sel;
  logic [BIT_W-1:0]     bit_low;
  logic [BM_AW-1:0]     bm_addr;
  logic [BM_AW-1:0]     bm_raddr;
  logic [BM_DEPTH-1:0]  bm_vld;
  logic [NUM_CLASSES-1:0] cnt_vld;

  logic [ADDR_W-1:0]    free_cls;
  logic [ADDR_W-1:0]    free_slot;
  logic [WI_W-1:0]      free_word;
  logic [BIT_W-1:0]     free_bit;

  logic                 bm_we;
  logic [WORD_BITS-1:0] bm_wdata;
  logic [WORD_BITS-1:0] bm_rdata;
  logic [WORD_BITS-1:0] bm_word;
  logic                 cnt_we;
  logic [CLS_W-1:0]     cnt_raddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic [CNT_W-1:0]     cnt_rdata;
  logic [CNT_W-1:0]     cnt_word;

  logic                 res_load;
  logic [STATUS_W-1:0]  res_status_next;
  logic [ADDR_W-1:0]    res_addr_next;
  logic [STATUS_W-1:0]  res_status;
  logic [ADDR_W-1:0]    res_addr;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ADDR_W-1:0]    out_addr;
  logic                 out_free;

  scba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scba_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient)
  );

  scba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_addr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  scba_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_CLASSES)
  ) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cls),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign step_eff  = (cfg.size_step < STEP_FLOOR) ? STEP_FLOOR : cfg.size_step;
  assign cls_wide  = (quo > rq) ? (quo - rq) : '0;
  assign bm_word   = bm_vld[bm_addr] ? bm_rdata : word_init(word_idx);
  assign cnt_word  = cnt_vld[cls] ? cnt_rdata : CNT_W'(SLOTS);
  assign bit_low   = lowest_one(bm_word);
  assign out_free  = !out_valid || rsp.ready;
  assign free_cls  = req.address / ADDR_W'(SLOTS);
  assign free_slot = req.address % ADDR_W'(SLOTS);
  assign free_word = WI_W'(free_slot / ADDR_W'(WORD_BITS));
  assign free_bit  = BIT_W'(free_slot % ADDR_W'(WORD_BITS));

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.address_res = out_addr;

  always_comb begin
    state_next      = state;
    div_start       = 1'b0;
    div_dividend    = '0;
    div_divisor     = DVS_W'(step_eff);
    bm_raddr        = bm_addr;
    cnt_raddr       = cls;
    bm_we           = 1'b0;
    bm_wdata        = bm_word;
    cnt_we          = 1'b0;
    cnt_wdata       = cnt_word;
    res_load        = 1'b0;
    res_status_next = ST_ALLOC;
    res_addr_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_FREE) begin
            if (free_cls >= ADDR_W'(NUM_CLASSES)) begin
              res_load        = 1'b1;
              res_status_next = ST_DOUBLE;
              state_next      = S_OUT;
            end else begin
              bm_raddr   = BM_AW'(int'(free_cls) * WPC + int'(free_word));
              cnt_raddr  = CLS_W'(free_cls);
              state_next = S_FREE_CHK;
            end
          end else if (req.size == '0) begin
            res_load        = 1'b1;
            res_status_next = ST_ZERO;
            state_next      = S_OUT;
          end else if (req.size > SIZE_W'(cfg.size_max)) begin
            res_load        = 1'b1;
            res_status_next = ST_LARGE;
            state_next      = S_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(req.size) + DVD_W'(step_eff) - DVD_W'(1);
            state_next   = S_DIV_Q;
          end
        end
      end
      S_DIV_Q: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DVD_W'(cfg.size_min) + DVD_W'(step_eff) - DVD_W'(1);
          state_next   = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (div_done) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (cls_wide >= DVD_W'(NUM_CLASSES)) begin
          res_load        = 1'b1;
          res_status_next = ST_LARGE;
          state_next      = S_OUT;
        end else begin
          cnt_raddr  = CLS_W'(cls_wide);
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        if (cnt_word == '0) begin
          res_load        = 1'b1;
          res_status_next = ST_FULL;
          state_next      = S_OUT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        bm_raddr   = BM_AW'(int'(cls) * WPC + int'(word_idx));
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (bm_word != '0) begin
          bm_we           = 1'b1;
          bm_wdata        = bm_word & ~(WORD_BITS'(1) << bit_low);
          cnt_we          = 1'b1;
          cnt_wdata       = cnt_word - CNT_W'(1);
          res_load        = 1'b1;
          res_status_next = ST_ALLOC;
          res_addr_next   = ADDR_W'(int'(cls) * SLOTS + int'(word_idx) * WORD_BITS
                                    + int'(bit_low));
          state_next      = S_OUT;
        end else if (word_idx == WI_W'(WPC - 1)) begin
          res_load        = 1'b1;
          res_status_next = ST_FULL;
          state_next      = S_OUT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_FREE_CHK: begin
        res_load = 1'b1;
        if (bm_word[bit_sel]) begin
          res_status_next = ST_DOUBLE;
        end else begin
          bm_we           = 1'b1;
          bm_wdata        = bm_word | (WORD_BITS'(1) << bit_sel);
          cnt_we          = 1'b1;
          cnt_wdata       = (cnt_word < CNT_W'(SLOTS)) ? cnt_word + CNT_W'(1) : cnt_word;
          res_status_next = ST_FREED;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bm_vld    <= '0;
      cnt_vld   <= '0;
    end else begin
      state <= state_next;
      if (bm_we) begin
        bm_vld[bm_addr] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_vld[cls] <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bm_addr <= bm_raddr;
    if (res_load) begin
      res_status <= res_status_next;
      res_addr   <= res_addr_next;
    end
    if (state == S_OUT && out_free) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
    if (state == S_DIV_Q && div_done) begin
      quo <= div_quotient;
    end
    if (state == S_DIV_R && div_done) begin
      rq <= div_quotient;
    end
    if (state == S_CLASS) begin
      cls      <= CLS_W'(cls_wide);
      word_idx <= '0;
    end
    if (state == S_SCAN_CHK && bm_word == '0) begin
      word_idx <= word_idx + WI_W'(1);
    end
    if (state == S_IDLE && req.valid && req.command == CMD_FREE) begin
      cls      <= CLS_W'(free_cls);
      word_idx <= free_word;
      bit_sel  <= free_bit;
    end
  end

endmodule

// ----- bench/tb_size_class_bitmap_slot_allocator.sv -----
// Self-checking bench for the size class slot allocator: drives allocate and free requests and checks each response.
module tb_size_class_bitmap_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import scba_pkg::*;

  localparam int CLASSES     = 16;
  localparam int SLOTS       = 256;
  localparam int WORD_BITS   = 32;
  localparam int WORDS       = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_LEN    = 400;
  localparam int SETTLE      = 60;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] address;
  } slot_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address_res;
  } slot_rsp_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scba_req_if req_ch ();
  scba_rsp_if rsp_ch ();

  size_class_bitmap_slot_allocator #(
    .NUM_CLASSES(CLASSES),
    .SLOTS      (SLOTS),
    .WORD_BITS  (WORD_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  logic [WORD_BITS-1:0] free_map [CLASSES*WORDS];
  int unsigned          free_slots [CLASSES];
  logic [MIN_W-1:0]     cur_min;
  logic [MIN_W-1:0]     cur_max;
  logic [STEP_W-1:0]    cur_step;

  slot_req_t   pending_reqs [$];
  slot_rsp_t   awaited_rsps [$];
  slot_rsp_t   predicted;
  slot_rsp_t   observed;
  slot_rsp_t   oldest;
  slot_req_t   next_req;
  logic [ADDR_W-1:0] granted_addr;
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned hold_reqs;
  int unsigned hold_done;
  int unsigned hold_cnt;
  int unsigned quiet_cycles;
  int unsigned errors = 0;

  wire req_fire = req_ch.valid && req_ch.ready;
  wire rsp_fire = rsp_ch.valid && rsp_ch.ready;

  function automatic int unsigned eff_step();
    return (cur_step < STEP_FLOOR) ? int'(STEP_FLOOR) : int'(cur_step);
  endfunction

  function automatic logic [STATUS_W-1:0] take_slot(input logic [SIZE_W-1:0] size,
                                                    output logic [ADDR_W-1:0] slot_addr);
    int unsigned stp, rounded, cls, w, b, row;
    stp = eff_step();
    slot_addr = '0;
    if (size == 0) return ST_ZERO;
    if (size > cur_max) return ST_LARGE;
    rounded = ((size + stp - 1) / stp) * stp;
    cls = (rounded <= cur_min) ? 0 : (rounded - cur_min) / stp;
    if (cls >= CLASSES) return ST_LARGE;
    if (free_slots[cls] == 0) return ST_FULL;
    for (w = 0; w < WORDS; w++) begin
      row = cls * WORDS + w;
      if (free_map[row] != '0) begin
        for (b = 0; b < WORD_BITS; b++) begin
          if (free_map[row][b]) break;
        end
        free_map[row][b] = 1'b0;
        free_slots[cls]--;
        slot_addr = ADDR_W'(cls * SLOTS + w * WORD_BITS + b);
        return ST_ALLOC;
      end
    end
    return ST_FULL;
  endfunction

  function automatic logic [STATUS_W-1:0] return_slot(input logic [ADDR_W-1:0] address);
    int unsigned cls, slot, row, b;
    cls = address / SLOTS;
    slot = address % SLOTS;
    if (cls >= CLASSES) return ST_DOUBLE;
    row = cls * WORDS + slot / WORD_BITS;
    b = slot % WORD_BITS;
    if (free_map[row][b]) return ST_DOUBLE;
    free_map[row][b] = 1'b1;
    if (free_slots[cls] < SLOTS) free_slots[cls]++;
    return ST_FREED;
  endfunction

  function automatic logic [SIZE_W-1:0] size_for_class(input int unsigned cls);
    int unsigned stp, lo;
    stp = eff_step();
    if (cls == 0) return SIZE_W'($urandom_range((cur_min > 0) ? int'(cur_min) : 1, 1));
    lo = cur_min + (cls - 1) * stp + 1 + $urandom_range(stp - 1, 0);
    return (lo > 65535) ? 16'hffff : SIZE_W'(lo);
  endfunction

  task automatic add_req(input logic cmd, input int unsigned size, input int unsigned addr);
    slot_req_t r;
    r.command = cmd;
    r.size = SIZE_W'(size);
    r.address = ADDR_W'(addr);
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(input int unsigned hot, input int unsigned count);
    int unsigned r, cls, top;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      cls = (r % 2 == 0) ? hot : $urandom_range(CLASSES - 1);
      top = cur_max + 2 * eff_step();
      if (r < 50) add_req(CMD_ALLOC, size_for_class(cls), $urandom());
      else if (r < 58) add_req(CMD_ALLOC, $urandom_range(top, 0), $urandom());
      else if (r < 62) add_req(CMD_ALLOC, $urandom(), $urandom());
      else if (r < 64) add_req(CMD_ALLOC, 0, $urandom());
      else if (r < 92) add_req(CMD_FREE, $urandom(), cls * SLOTS + $urandom_range(47, 0));
      else add_req(CMD_FREE, $urandom(), $urandom());
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIZE_MIN:  cur_min  = MIN_W'(value);
      REG_SIZE_MAX:  cur_max  = MIN_W'(value);
      REG_SIZE_STEP: cur_step = STEP_W'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned mn, input int unsigned mx, input int unsigned st);
    write_reg(REG_SIZE_MIN, mn);
    write_reg(REG_SIZE_MAX, mx);
    write_reg(REG_SIZE_STEP, st);
  endtask

  task automatic wait_drained(input int unsigned extra);
    while (pending_reqs.size() != 0 || req_ch.valid || awaited_rsps.size() != 0) begin
      @(negedge clk);
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic report(input string what, input slot_rsp_t exp_rsp, input slot_rsp_t got_rsp);
    if (errors < 10) begin
      $display("mismatch (%s): expected status %0d addr %0d, got status %0d addr %0d",
               what, exp_rsp.status, exp_rsp.address_res, got_rsp.status,
               got_rsp.address_res);
    end
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      for (int c = 0; c < CLASSES; c++) begin
        free_slots[c] = SLOTS;
        for (int w = 0; w < WORDS; w++) free_map[c * WORDS + w] = '1;
      end
    end else begin
      if (req_fire) begin
        granted_addr = '0;
        if (req_ch.command == CMD_ALLOC) begin
          predicted.status = take_slot(req_ch.size, granted_addr);
        end else begin
          predicted.status = return_slot(req_ch.address);
        end
        predicted.address_res = granted_addr;
        awaited_rsps.push_back(predicted);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.command <= next_req.command;
          req_ch.size    <= next_req.size;
          req_ch.address <= next_req.address;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 0;
    end else begin
      if (rsp_fire) begin
        observed.status = rsp_ch.status;
        observed.address_res = rsp_ch.address_res;
        if (awaited_rsps.size() == 0) begin
          report("unexpected", '0, observed);
        end else begin
          oldest = awaited_rsps.pop_front();
          if (oldest.status !== observed.status ||
              oldest.address_res !== observed.address_res) begin
            report("response", oldest, observed);
          end
        end
      end
      if (hold_reqs != hold_done) begin
        rsp_ch.ready <= 1'b0;
        if (hold_cnt == HOLD_LEN) begin
          hold_cnt <= 0;
          hold_done <= hold_done + 1;
        end else begin
          hold_cnt <= hold_cnt + 1;
        end
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || req_fire || rsp_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_reqs = 0;
    cur_min = SIZE_MIN_RST;
    cur_max = SIZE_MAX_RST;
    cur_step = SIZE_STEP_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_req(CMD_ALLOC, 0, 0);
    add_req(CMD_ALLOC, 1, 0);
    add_req(CMD_ALLOC, 8, 0);
    add_req(CMD_ALLOC, 9, 0);
    add_req(CMD_ALLOC, 128, 0);
    add_req(CMD_ALLOC, 129, 0);
    add_req(CMD_ALLOC, 65535, 4095);
    add_req(CMD_FREE, 0, 0);
    add_req(CMD_FREE, 0, 0);
    add_req(CMD_FREE, 65535, 4095);
    add_req(CMD_ALLOC, 5, 0);
    add_req(CMD_FREE, 0, 256);
    add_req(CMD_FREE, 0, 3840);
    add_req(CMD_ALLOC, 120, 0);
    add_req(CMD_FREE, 0, 2047);
    add_req(CMD_ALLOC, 7, 0);
    add_req(CMD_ALLOC, 127, 2730);
    add_req(CMD_FREE, 43690, 1365);
    add_random(0, 230);
    wait_drained(SETTLE);

    configure(0, 4096, 4);
    send_idle_pct = 63;
    for (int i = 0; i < 270; i++) add_req(CMD_ALLOC, size_for_class(1), $urandom());
    add_random(1, 130);
    wait_drained(SETTLE);

    configure(4096, 4096, 256);
    send_idle_pct = 0;
    rsp_stall_pct = 63;
    hold_reqs = hold_reqs + 1;
    add_random(0, 300);
    wait_drained(SETTLE);

    configure(100, 1000, 2);
    send_idle_pct = 22;
    rsp_stall_pct = 22;
    add_random(3, 350);
    wait_drained(SETTLE);

    configure(8, 128, 8);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    add_random(5, 200);
    wait_drained(0);
    add_random(15, 200);
    wait_drained(SETTLE);

    configure(0, 4, 0);
    send_idle_pct = 22;
    rsp_stall_pct = 22;
    add_random(1, 200);
    wait_drained(SETTLE);

    if (errors == 0 && awaited_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/scba_pkg.sv
sv/scba_if.sv
sv/scba_ram.sv
sv/scba_div.sv
sv/scba_cfg.sv
sv/size_class_bitmap_slot_allocator.sv
bench/tb_size_class_bitmap_slot_allocator.sv
